// ===== rtl/core/bchf_pkg.sv =====
// ----------------------------------------------------------------------------
// bchf_pkg
// Types, codes and helpers shared by the beacon/collision handshake block.
// ----------------------------------------------------------------------------
package bchf_pkg;

  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_LISTEN      = 3'd1,
    PH_SEND_COLL   = 3'd2,
    PH_AWAIT       = 3'd3,
    PH_DETECTED    = 3'd4,
    PH_SEND_BEACON = 3'd5,
    PH_SEND_ACK    = 3'd6
  } phase_t;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_PASS = 2'd1;
  localparam logic [1:0] KIND_MSG  = 2'd2;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_LISTEN_WINDOW = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_WINDOW    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_NUMBER = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BEACON_CODE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COLLISION_CODE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_CODE      = 3'd5;

  localparam logic [15:0] RST_LISTEN_WINDOW = 16'd1000;
  localparam logic [15:0] RST_ACK_WINDOW    = 16'd100;
  localparam logic [23:0] RST_DEVICE_NUMBER = 24'd1;
  localparam logic [7:0]  RST_BEACON_CODE   = 8'h24;
  localparam logic [7:0]  RST_COLLISION_CODE = 8'hDB;
  localparam logic [7:0]  RST_ACK_CODE      = 8'h81;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] listen_window_ms;
    logic [15:0] ack_window_ms;
    logic [23:0] device_number;
    logic [7:0]  beacon_code;
    logic [7:0]  collision_code;
    logic [7:0]  ack_code;
  } cfg_t;

  typedef struct packed {
    logic        tx_valid;
    logic [31:0] tx_word;
    logic        listening;
    logic        rx_taken;
    phase_t      phase_now;
    logic        detected_pulse;
  } res_t;

  function automatic logic [31:0] make_word(input logic [7:0] code,
                                            input logic [23:0] dev);
    make_word = {code, dev};
  endfunction

endpackage

// ===== rtl/core/bchf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bchf_ctrl
// Phase machine and millisecond timer; forms one result per transfer.
// ----------------------------------------------------------------------------
module bchf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [1:0]      kind,
  input  logic [31:0]     rx_word,
  input  bchf_pkg::cfg_t  cfg,
  output bchf_pkg::res_t  res
);
  import bchf_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] elapsed, elapsed_next;
  logic        radio_listening, radio_listening_next;
  logic        listen_pending, listen_pending_next;
  logic        await_pending, await_pending_next;
  logic        reply_pending, reply_pending_next;
  logic        detect_unannounced, detect_unannounced_next;

  logic [7:0]  top;
  logic        has_msg;

  assign top     = rx_word[31:24];
  assign has_msg = (kind == KIND_MSG);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_START;
      elapsed            <= '0;
      radio_listening    <= 1'b0;
      listen_pending     <= 1'b1;
      await_pending      <= 1'b1;
      reply_pending      <= 1'b1;
      detect_unannounced <= 1'b1;
    end else if (accept) begin
      phase              <= phase_next;
      elapsed            <= elapsed_next;
      radio_listening    <= radio_listening_next;
      listen_pending     <= listen_pending_next;
      await_pending      <= await_pending_next;
      reply_pending      <= reply_pending_next;
      detect_unannounced <= detect_unannounced_next;
    end
  end

  always_comb begin
    phase_next              = phase;
    elapsed_next            = elapsed;
    radio_listening_next    = radio_listening;
    listen_pending_next     = listen_pending;
    await_pending_next      = await_pending;
    reply_pending_next      = reply_pending;
    detect_unannounced_next = detect_unannounced;
    res.tx_valid            = 1'b0;
    res.tx_word             = '0;
    res.rx_taken            = 1'b0;
    res.detected_pulse      = 1'b0;

    if (kind == KIND_TICK) begin
      if (elapsed != ELAPSED_MAX) begin
        elapsed_next = elapsed + 16'd1;
      end
    end else begin
      case (phase)
        PH_START: begin
          listen_pending_next     = 1'b1;
          await_pending_next      = 1'b1;
          reply_pending_next      = 1'b1;
          detect_unannounced_next = 1'b1;
          radio_listening_next    = 1'b1;
          phase_next              = PH_LISTEN;
        end
        PH_LISTEN: begin
          if (listen_pending) begin
            elapsed_next        = '0;
            listen_pending_next = 1'b0;
          end else if (elapsed <= cfg.listen_window_ms) begin
            if (has_msg) begin
              res.rx_taken = 1'b1;
              if (top == cfg.beacon_code) begin
                phase_next = PH_SEND_COLL;
              end else if (top == cfg.collision_code) begin
                phase_next = PH_SEND_ACK;
              end
            end
          end else begin
            elapsed_next = '0;
            phase_next   = PH_SEND_BEACON;
          end
        end
        PH_SEND_COLL: begin
          radio_listening_next = 1'b0;
          res.tx_valid         = 1'b1;
          res.tx_word          = make_word(cfg.collision_code, cfg.device_number);
          phase_next           = PH_AWAIT;
        end
        PH_AWAIT: begin
          if (await_pending) begin
            elapsed_next       = '0;
            await_pending_next = 1'b0;
          end else begin
            radio_listening_next = 1'b1;
            if (has_msg) begin
              res.rx_taken = 1'b1;
            end
            if (has_msg && top == cfg.ack_code) begin
              phase_next = PH_DETECTED;
            end else if (elapsed > cfg.ack_window_ms) begin
              await_pending_next = 1'b1;
              phase_next         = PH_SEND_COLL;
            end
          end
        end
        PH_DETECTED: begin
          if (detect_unannounced) begin
            res.detected_pulse      = 1'b1;
            detect_unannounced_next = 1'b0;
          end
        end
        PH_SEND_BEACON: begin
          radio_listening_next = 1'b0;
          res.tx_valid         = 1'b1;
          res.tx_word          = make_word(cfg.beacon_code, cfg.device_number);
          phase_next           = PH_START;
        end
        PH_SEND_ACK: begin
          if (reply_pending) begin
            elapsed_next       = '0;
            reply_pending_next = 1'b0;
          end else begin
            radio_listening_next = 1'b0;
            res.tx_valid         = 1'b1;
            res.tx_word          = make_word(cfg.ack_code, cfg.device_number);
            if (elapsed > cfg.ack_window_ms) begin
              phase_next = PH_DETECTED;
            end
          end
        end
        default: begin
        end
      endcase
    end

    res.listening = radio_listening_next;
    res.phase_now = phase_next;
  end

  a_tick_holds_phase: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_TICK) |=> (phase == $past(phase)))
    else $error("tick transfer changed the phase");

  a_detected_terminal: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DETECTED) |=> (phase == PH_DETECTED))
    else $error("left the detected phase without reset");

  a_coll_rearms_await: assert property (@(posedge clk) disable iff (rst)
    (accept && kind != KIND_TICK && phase == PH_SEND_COLL)
      |=> (phase == PH_AWAIT && await_pending))
    else $error("collision send did not re-arm the acknowledge wait");

  a_single_pulse: assert property (@(posedge clk) disable iff (rst)
    (accept && res.detected_pulse) |=> !detect_unannounced)
    else $error("detection pulse not retired");

endmodule

// ===== rtl/core/bchf_obuf.sv =====
// ----------------------------------------------------------------------------
// bchf_obuf
// Two-entry result buffer; the head entry drives the result port.
// ----------------------------------------------------------------------------
module bchf_obuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bchf_pkg::res_t  push_data,
  output logic            full,
  output logic            head_valid,
  input  logic            head_stall,
  output bchf_pkg::res_t  head
);
  import bchf_pkg::*;

  res_t       tail;
  logic [1:0] count;
  logic       pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign pop        = head_valid && !head_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        tail <= push_data;
      end
    end else if (pop && !push) begin
      head <= tail;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        head <= push_data;
      end else begin
        head <= tail;
        tail <= push_data;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |=> (count != 2'd3))
    else $error("result buffer overflow");

endmodule

// ===== rtl/core/beacon_collision_handshake_fsm.sv =====
// ----------------------------------------------------------------------------
// beacon_collision_handshake_fsm
// Radio link beacon/collision/acknowledge handshake controller.
// ----------------------------------------------------------------------------
// One item (millisecond tick, processing pass or message) is taken every cycle
// while item_stall is low; its result is registered into the result buffer.
// The phase machine and timer update once per transfer; a two-entry result
// buffer lets input keep flowing while a result is held by a stalled consumer,
// so item_stall rises only with both entries occupied; cfg_ready is tied high.
module beacon_collision_handshake_fsm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [1:0]                          kind,
  input  logic [31:0]                         rx_word,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                tx_valid,
  output logic [31:0]                         tx_word,
  output logic                                listening,
  output logic                                rx_taken,
  output logic [2:0]                          phase_now,
  output logic                                detected_pulse,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bchf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bchf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bchf_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t head;
  logic accept;
  logic full;

  assign cfg_ready  = 1'b1;
  assign item_stall = full;
  assign accept     = item_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.listen_window_ms <= RST_LISTEN_WINDOW;
      cfg.ack_window_ms    <= RST_ACK_WINDOW;
      cfg.device_number    <= RST_DEVICE_NUMBER;
      cfg.beacon_code      <= RST_BEACON_CODE;
      cfg.collision_code   <= RST_COLLISION_CODE;
      cfg.ack_code         <= RST_ACK_CODE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LISTEN_WINDOW:  cfg.listen_window_ms <= cfg_data[15:0];
        REG_ACK_WINDOW:     cfg.ack_window_ms    <= cfg_data[15:0];
        REG_DEVICE_NUMBER:  cfg.device_number    <= cfg_data[23:0];
        REG_BEACON_CODE:    cfg.beacon_code      <= cfg_data[7:0];
        REG_COLLISION_CODE: cfg.collision_code   <= cfg_data[7:0];
        REG_ACK_CODE:       cfg.ack_code         <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  bchf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .kind    (kind),
    .rx_word (rx_word),
    .cfg     (cfg),
    .res     (res)
  );

  bchf_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (res),
    .full       (full),
    .head_valid (result_valid),
    .head_stall (result_stall),
    .head       (head)
  );

  assign tx_valid       = head.tx_valid;
  assign tx_word        = head.tx_word;
  assign listening      = head.listening;
  assign rx_taken       = head.rx_taken;
  assign phase_now      = head.phase_now;
  assign detected_pulse = head.detected_pulse;

endmodule

// ===== test/bchf_link_checker.sv =====
// ----------------------------------------------------------------------------
// bchf_link_checker
// Watches the item, result and register channels of the beacon/collision
// handshake block. It predicts each result from its own copy of the phase
// machine and registers, and compares every result field with the oldest
// prediction still owed.
// ----------------------------------------------------------------------------
module bchf_link_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  input  logic                             item_stall,
  input  logic [1:0]                       kind,
  input  logic [31:0]                      rx_word,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  logic                             tx_valid,
  input  logic [31:0]                      tx_word,
  input  logic                             listening,
  input  logic                             rx_taken,
  input  logic [2:0]                       phase_now,
  input  logic                             detected_pulse,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bchf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bchf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import bchf_pkg::*;

  cfg_t        link_cfg;
  phase_t      link_phase;
  logic [15:0] elapsed_ms;
  logic        radio_rx;
  logic        listen_fresh;
  logic        await_fresh;
  logic        reply_fresh;
  logic        detect_fresh;

  res_t        replies_due[$];
  res_t        want;
  int          results_seen;

  initial begin
    fail_count   = 0;
    results_owed = 0;
    results_seen = 0;
  end

  task automatic advance_link(input logic [1:0] k, input logic [31:0] w, output res_t r);
    logic [7:0] top_byte;
    logic       has_msg;
    logic       got_ack;
    top_byte = w[31:24];
    has_msg  = (k == KIND_MSG);
    got_ack  = 1'b0;
    r        = '0;
    if (k == KIND_TICK) begin
      if (elapsed_ms != ELAPSED_MAX) elapsed_ms = elapsed_ms + 16'd1;
    end else begin
      case (link_phase)
        PH_START: begin
          listen_fresh = 1'b1;
          await_fresh  = 1'b1;
          reply_fresh  = 1'b1;
          detect_fresh = 1'b1;
          radio_rx     = 1'b1;
          link_phase   = PH_LISTEN;
        end
        PH_LISTEN: begin
          if (listen_fresh) begin
            elapsed_ms   = '0;
            listen_fresh = 1'b0;
          end else if (elapsed_ms <= link_cfg.listen_window_ms) begin
            if (has_msg) begin
              r.rx_taken = 1'b1;
              // beacon takes priority when both codes match
              if (top_byte == link_cfg.collision_code) link_phase = PH_SEND_ACK;
              if (top_byte == link_cfg.beacon_code) link_phase = PH_SEND_COLL;
            end
          end else begin
            elapsed_ms = '0;
            link_phase = PH_SEND_BEACON;
          end
        end
        PH_SEND_COLL: begin
          radio_rx   = 1'b0;
          r.tx_valid = 1'b1;
          r.tx_word  = {link_cfg.collision_code, link_cfg.device_number};
          link_phase = PH_AWAIT;
        end
        PH_AWAIT: begin
          if (await_fresh) begin
            elapsed_ms  = '0;
            await_fresh = 1'b0;
          end else begin
            radio_rx = 1'b1;
            if (has_msg) begin
              r.rx_taken = 1'b1;
              if (top_byte == link_cfg.ack_code) begin
                link_phase = PH_DETECTED;
                got_ack    = 1'b1;
              end
            end
            if (!got_ack && elapsed_ms > link_cfg.ack_window_ms) begin
              await_fresh = 1'b1;
              link_phase  = PH_SEND_COLL;
            end
          end
        end
        PH_DETECTED: begin
          if (detect_fresh) begin
            r.detected_pulse = 1'b1;
            detect_fresh     = 1'b0;
          end
        end
        PH_SEND_BEACON: begin
          radio_rx   = 1'b0;
          r.tx_valid = 1'b1;
          r.tx_word  = {link_cfg.beacon_code, link_cfg.device_number};
          link_phase = PH_START;
        end
        PH_SEND_ACK: begin
          if (reply_fresh) begin
            elapsed_ms  = '0;
            reply_fresh = 1'b0;
          end else begin
            radio_rx   = 1'b0;
            r.tx_valid = 1'b1;
            r.tx_word  = {link_cfg.ack_code, link_cfg.device_number};
            if (elapsed_ms > link_cfg.ack_window_ms) link_phase = PH_DETECTED;
          end
        end
        default: ;
      endcase
    end
    r.listening = radio_rx;
    r.phase_now = link_phase;
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] result %0d: %s expected %h, got %h",
               $realtime, results_seen, field, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      link_cfg.listen_window_ms = RST_LISTEN_WINDOW;
      link_cfg.ack_window_ms    = RST_ACK_WINDOW;
      link_cfg.device_number    = RST_DEVICE_NUMBER;
      link_cfg.beacon_code      = RST_BEACON_CODE;
      link_cfg.collision_code   = RST_COLLISION_CODE;
      link_cfg.ack_code         = RST_ACK_CODE;
      link_phase   = PH_START;
      elapsed_ms   = '0;
      radio_rx     = 1'b0;
      listen_fresh = 1'b1;
      await_fresh  = 1'b1;
      reply_fresh  = 1'b1;
      detect_fresh = 1'b1;
      replies_due.delete();
    end else begin
      // an item on the same edge as a register write still sees the old value
      if (item_valid && !item_stall) begin
        advance_link(kind, rx_word, want);
        replies_due.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LISTEN_WINDOW:  link_cfg.listen_window_ms = cfg_data[15:0];
          REG_ACK_WINDOW:     link_cfg.ack_window_ms    = cfg_data[15:0];
          REG_DEVICE_NUMBER:  link_cfg.device_number    = cfg_data[23:0];
          REG_BEACON_CODE:    link_cfg.beacon_code      = cfg_data[7:0];
          REG_COLLISION_CODE: link_cfg.collision_code   = cfg_data[7:0];
          REG_ACK_CODE:       link_cfg.ack_code         = cfg_data[7:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        results_seen++;
        if (replies_due.size() == 0) begin
          flag_mismatch("transfer with nothing owed, tx_word", '0, tx_word);
        end else begin
          want = replies_due.pop_front();
          if (tx_valid !== want.tx_valid)
            flag_mismatch("tx_valid", 32'(want.tx_valid), 32'(tx_valid));
          if (tx_word !== want.tx_word) flag_mismatch("tx_word", want.tx_word, tx_word);
          if (listening !== want.listening)
            flag_mismatch("listening", 32'(want.listening), 32'(listening));
          if (rx_taken !== want.rx_taken)
            flag_mismatch("rx_taken", 32'(want.rx_taken), 32'(rx_taken));
          if (phase_now !== want.phase_now)
            flag_mismatch("phase_now", 32'(want.phase_now), 32'(phase_now));
          if (detected_pulse !== want.detected_pulse)
            flag_mismatch("detected_pulse", 32'(want.detected_pulse),
                          32'(detected_pulse));
        end
      end
    end
    results_owed = replies_due.size();
  end

endmodule

// ===== test/tb_beacon_collision_handshake_fsm.sv =====
// ----------------------------------------------------------------------------
// tb_beacon_collision_handshake_fsm
// Drives ticks, passes and received messages into the handshake block through
// the listen/beacon loop, long tick runs and one of the two terminal routes
// (collision resend loop or acknowledge repeat), with register changes between
// stretches and random sender gaps and receiver stalls. Checking is done by
// bchf_link_checker.
// ----------------------------------------------------------------------------
module tb_beacon_collision_handshake_fsm;
  timeunit 1ns;
  timeprecision 1ps;

  import bchf_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_stall;
  logic [1:0]             kind;
  logic [31:0]            rx_word;
  logic                   result_valid;
  logic                   result_stall;
  logic                   tx_valid;
  logic [31:0]            tx_word;
  logic                   listening;
  logic                   rx_taken;
  logic [2:0]             phase_now;
  logic                   detected_pulse;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int         fail_count;
  int         results_owed;
  int         cycle_count;
  int         burst_left;
  int         stall_span;
  rx_mode_t   stall_mode;
  logic [7:0] sh_beacon;
  logic [7:0] sh_collision;
  logic [7:0] sh_ack;

  beacon_collision_handshake_fsm uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .rx_word(rx_word),
    .result_valid(result_valid), .result_stall(result_stall),
    .tx_valid(tx_valid), .tx_word(tx_word), .listening(listening),
    .rx_taken(rx_taken), .phase_now(phase_now), .detected_pulse(detected_pulse),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bchf_link_checker chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .rx_word(rx_word),
    .result_valid(result_valid), .result_stall(result_stall),
    .tx_valid(tx_valid), .tx_word(tx_word), .listening(listening),
    .rx_taken(rx_taken), .phase_now(phase_now), .detected_pulse(detected_pulse),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver stall pattern, changes character whenever its random span runs out
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(50, 400);
    end
    stall_span--;
    case (stall_mode)
      RX_FREE:  result_stall <= 1'b0;
      RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: result_stall <= ($urandom_range(0, 9) < 6);
      default:  result_stall <= (stall_span % 4 == 0);
    endcase
  end

  function automatic logic [7:0] top_avoiding(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    while (t == a || t == b) t = 8'($urandom_range(0, 255));
    return t;
  endfunction

  function automatic logic [31:0] rand_word(input logic [7:0] top_byte);
    logic [31:0] w;
    w = $urandom;
    return {top_byte, w[23:0]};
  endfunction

  task automatic push_item(input logic [1:0] k, input logic [31:0] w);
    int gap;
    if (burst_left <= 0) begin
      item_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    item_valid <= 1'b1;
    kind       <= k;
    rx_word    <= w;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    burst_left--;
  endtask

  // messages never carry a top byte equal to avoid_a or avoid_b
  task automatic random_item(input logic [7:0] avoid_a, input logic [7:0] avoid_b);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) push_item(KIND_TICK, $urandom);
    else if (pick < 60) push_item(KIND_PASS, $urandom);
    else push_item(KIND_MSG, rand_word(top_avoiding(avoid_a, avoid_b)));
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    item_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BEACON_CODE:    sh_beacon    = val[7:0];
      REG_COLLISION_CODE: sh_collision = val[7:0];
      REG_ACK_CODE:       sh_ack       = val[7:0];
      default: ;
    endcase
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    kind         = KIND_TICK;
    rx_word      = '0;
    result_stall = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_LISTEN_WINDOW;
    cfg_data     = '0;
    cycle_count  = 0;
    burst_left   = 0;
    stall_span   = 0;
    stall_mode   = RX_FREE;
    sh_beacon    = RST_BEACON_CODE;
    sh_collision = RST_COLLISION_CODE;
    sh_ack       = RST_ACK_CODE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset registers: entry pass, non-matching messages
    push_item(KIND_PASS, 32'h0000_0000);
    push_item(KIND_PASS, 32'hFFFF_FFFF);
    push_item(KIND_MSG, 32'h0000_0000);
    push_item(KIND_MSG, 32'hFFFF_FFFF);
    push_item(KIND_TICK, 32'h5A5A_5A5A);
    push_item(KIND_MSG, {RST_ACK_CODE, 24'hABCDEF});
    push_item(KIND_PASS, 32'h0000_0000);

    // zero listen window: timeout, beacon, entry pass ignores a beacon
    write_reg(REG_LISTEN_WINDOW, 24'd0);
    push_item(KIND_TICK, 32'hA5A5_A5A5);
    push_item(KIND_PASS, 32'h0000_0000);
    push_item(KIND_MSG, {RST_BEACON_CODE, 24'h000001});
    push_item(KIND_PASS, 32'h0000_0000);
    push_item(KIND_MSG, {RST_BEACON_CODE, 24'hFFFFFF});
    push_item(KIND_MSG, 32'h1234_5678);
    push_item(KIND_TICK, 32'h0000_0000);
    push_item(KIND_MSG, {RST_COLLISION_CODE, 24'h000000});
    push_item(KIND_PASS, 32'h0000_0000);

    // listen / beacon loop under several register settings
    for (int s = 0; s < 4; s++) begin
      logic [7:0]  b;
      logic [7:0]  c;
      logic [23:0] dev;
      case (s)
        1: begin b = 8'h00; c = 8'hFF; dev = 24'h000000; end
        2: begin b = 8'hFF; c = 8'h00; dev = 24'hFFFFFF; end
        default: begin
          b   = 8'($urandom_range(0, 255));
          c   = top_avoiding(b, b);
          dev = 24'($urandom);
        end
      endcase
      write_reg(REG_LISTEN_WINDOW, 24'($urandom_range(0, 12)));
      write_reg(REG_ACK_WINDOW, 24'($urandom_range(0, 20)));
      write_reg(REG_DEVICE_NUMBER, dev);
      write_reg(REG_BEACON_CODE, {16'd0, b});
      write_reg(REG_COLLISION_CODE, {16'd0, c});
      write_reg(REG_ACK_CODE, 24'($urandom_range(0, 255)));
      repeat (300) random_item(sh_beacon, sh_collision);
    end

    // wider listen window: a long run of ticks ends it
    write_reg(REG_LISTEN_WINDOW, 24'd100);
    repeat (4) push_item(KIND_PASS, $urandom);
    repeat (120) push_item(KIND_TICK, $urandom);
    push_item(KIND_MSG, rand_word(top_avoiding(sh_beacon, sh_collision)));
    push_item(KIND_PASS, $urandom);

    write_reg(REG_LISTEN_WINDOW, 24'd200);
    write_reg(REG_ACK_WINDOW, 24'd1000);
    repeat (4) push_item(KIND_PASS, $urandom);

    if ($urandom_range(0, 1) == 0) begin
      // beacon heard: collision resend loop, then acknowledge
      if ($urandom_range(0, 1) == 0) write_reg(REG_COLLISION_CODE, {16'd0, sh_beacon});
      push_item(KIND_MSG, rand_word(sh_beacon));
      for (int s = 0; s < 4; s++) begin
        logic [15:0] win;
        win = (s == 0) ? 16'd0 : (s == 2) ? 16'hFFFE : 16'($urandom_range(1, 15));
        write_reg(REG_ACK_WINDOW, {8'd0, win});
        write_reg(REG_DEVICE_NUMBER, 24'($urandom));
        if (s == 3) write_reg(REG_COLLISION_CODE, 24'($urandom_range(0, 255)));
        repeat ((s == 2) ? 60 : 150) random_item(sh_ack, sh_ack);
      end
      write_reg(REG_ACK_WINDOW, 24'd1000);
      repeat (3) push_item(KIND_PASS, $urandom);
      push_item(KIND_MSG, rand_word(sh_ack));
    end else begin
      // collision heard: acknowledge repeats until the window runs out
      push_item(KIND_MSG, rand_word(sh_collision));
      write_reg(REG_ACK_WINDOW, 24'hFFFE);
      repeat (150) random_item(sh_ack, sh_ack);
      write_reg(REG_DEVICE_NUMBER, 24'h000000);
      write_reg(REG_ACK_CODE, 24'hFF);
      repeat (100) random_item(sh_ack, sh_ack);
      write_reg(REG_DEVICE_NUMBER, 24'hFFFFFF);
      write_reg(REG_ACK_CODE, 24'h00);
      write_reg(REG_ACK_WINDOW, 24'($urandom_range(3, 15)));
      repeat (150) random_item(sh_ack, sh_ack);
      write_reg(REG_ACK_WINDOW, 24'd0);
    end
    repeat (30) random_item(sh_ack, sh_ack);

    item_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
